// File: rtl/btts_pkg.sv
// Shared types, constants and helper functions of the battery text triplet scanner.
// Used by every module of the block; depends on nothing.

package btts_pkg;

  localparam int HIST_DEPTH = 7;
  localparam int KEY_COUNT  = 14;
  localparam int KEY_BYTES  = HIST_DEPTH + 1;
  localparam int LEVEL_W    = 7;

  // Keywords are right-aligned: the final character sits in the low byte.
  localparam logic [8*KEY_BYTES-1:0] KEY_TEXT [KEY_COUNT] = '{
    64'("left"), 64'("right"), 64'("case"), 64'(" l:"), 64'(" r:"), 64'(" c:"),
    64'("l="), 64'("r="), 64'("c="), 64'("+xevent"), 64'("xevent:"),
    64'("+batt:"), 64'("battery:"), 64'("battery,")
  };
  localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd7, 4'd7, 4'd6, 4'd8, 4'd8
  };

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] NUM_MAX      = 8'd255;
  localparam logic [7:0] LEVEL_MAX    = 8'd100;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] value;
  } level_t;

  // One processed character as seen by the state-holding units.
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] char_low;
  } step_t;

  typedef struct packed {
    logic               found;
    logic               left_present;
    logic [LEVEL_W-1:0] left_level;
    logic               right_present;
    logic [LEVEL_W-1:0] right_level;
    logic               holder_present;
    logic [LEVEL_W-1:0] holder_level;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic level_t normalize_level(input logic [7:0] raw);
    level_t     r;
    logic [7:0] times_ten;
    times_ten = {raw[4:0], 3'b000} + {raw[6:0], 1'b0};
    r.valid = 1'b0;
    r.value = '0;
    if (raw >= 8'd1 && raw <= 8'd9) begin
      r.valid = 1'b1;
      r.value = times_ten[LEVEL_W-1:0];
    end else if (raw >= 8'd10 && raw <= LEVEL_MAX) begin
      r.valid = 1'b1;
      r.value = raw[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/btts_ifs.sv
// Valid/ready channel interfaces of the battery text triplet scanner.
// Depends on btts_pkg for the level width.

interface btts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface btts_result_if
  import btts_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               found;
  logic               left_present;
  logic [LEVEL_W-1:0] left_level;
  logic               right_present;
  logic [LEVEL_W-1:0] right_level;
  logic               holder_present;
  logic [LEVEL_W-1:0] holder_level;

  modport source (output valid, output found, output left_present, output left_level,
                  output right_present, output right_level, output holder_present,
                  output holder_level, input ready);
  modport sink   (input valid, input found, input left_present, input left_level,
                  input right_present, input right_level, input holder_present,
                  input holder_level, output ready);
endinterface

// File: rtl/btts_hint_match.sv
// Character history and keyword detector of the scanner.
// Depends on btts_pkg for the keyword table and step_t.

module btts_hint_match
  import btts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  step_t step,
  output logic  hint_now
);

  logic [7:0] history [HIST_DEPTH];
  logic       hint_seen;
  logic [7:0] win [KEY_BYTES];
  logic       match;

  // win[0] is the current character, win[j] the one j places earlier.
  always_comb begin
    win[0] = step.char_low;
    for (int j = 1; j < KEY_BYTES; j++) begin
      win[j] = history[j-1];
    end
  end

  always_comb begin
    logic hit;
    match = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      hit = 1'b1;
      for (int j = 0; j < KEY_BYTES; j++) begin
        if (4'(j) < KEY_LEN[k] && win[j] != KEY_TEXT[k][8*j +: 8]) begin
          hit = 1'b0;
        end
      end
      match = match | hit;
    end
  end

  assign hint_now = hint_seen | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      hint_seen <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) history[i] <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        hint_seen <= 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++) history[i] <= '0;
      end else begin
        hint_seen  <= hint_now;
        history[0] <= step.char_low;
        for (int i = 1; i < HIST_DEPTH; i++) history[i] <= history[i-1];
      end
    end
  end

endmodule

// File: rtl/btts_level_track.sv
// Number gathering, level normalization and best-window tracking of the scanner.
// Depends on btts_pkg for level_t, step_t, result_t and normalize_level.

module btts_level_track
  import btts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  step_t   step,
  input  logic    hint_now,
  output result_t result
);

  logic [7:0] number_accum;
  logic       in_number;
  level_t     prior_levels [2];
  logic [1:0] numbers_seen;
  logic       best_valid;
  logic [1:0] best_count;
  level_t     best_levels [3];

  logic        is_digit;
  logic [11:0] acc_wide;
  logic [7:0]  acc_new;
  logic        close_now;
  level_t      cur;
  logic [1:0]  cnt;
  logic        take_window;
  logic        found;
  level_t      fin_levels [3];
  logic        fin_best_ok;

  assign is_digit = step.char_low >= CHAR_ZERO && step.char_low <= CHAR_NINE;
  assign acc_wide = {4'b0, number_accum} * 12'd10 + {4'b0, step.char_low - CHAR_ZERO};
  assign acc_new  = !is_digit ? number_accum :
                    (acc_wide > {4'b0, NUM_MAX}) ? NUM_MAX : acc_wide[7:0];

  // At most one number closes per character: on a separator, or on the last byte.
  assign close_now = (in_number && !is_digit) || (step.last && (is_digit || in_number));
  assign cur       = normalize_level(acc_new);
  assign cnt       = 2'(prior_levels[0].valid) + 2'(prior_levels[1].valid) + 2'(cur.valid);
  assign take_window = close_now && numbers_seen == 2'd2 && (!best_valid || cnt > best_count);

  always_comb begin
    if (take_window) begin
      fin_levels[0] = prior_levels[0];
      fin_levels[1] = prior_levels[1];
      fin_levels[2] = cur;
      fin_best_ok   = cnt[1];
    end else begin
      fin_levels    = best_levels;
      fin_best_ok   = best_valid && best_count[1];
    end
    found = hint_now && fin_best_ok;
    result.found          = found;
    result.left_present   = found && fin_levels[0].valid;
    result.left_level     = result.left_present ? fin_levels[0].value : '0;
    result.right_present  = found && fin_levels[1].valid;
    result.right_level    = result.right_present ? fin_levels[1].value : '0;
    result.holder_present = found && fin_levels[2].valid;
    result.holder_level   = result.holder_present ? fin_levels[2].value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      number_accum <= '0;
      in_number    <= 1'b0;
      numbers_seen <= '0;
      best_valid   <= 1'b0;
      best_count   <= '0;
      for (int i = 0; i < 2; i++) prior_levels[i] <= '0;
      for (int i = 0; i < 3; i++) best_levels[i] <= '0;
    end else if (step.fire) begin
      if (is_digit) begin
        number_accum <= acc_new;
        in_number    <= 1'b1;
      end else if (close_now) begin
        number_accum    <= '0;
        in_number       <= 1'b0;
        prior_levels[0] <= prior_levels[1];
        prior_levels[1] <= cur;
        if (numbers_seen != 2'd2) begin
          numbers_seen <= numbers_seen + 2'd1;
        end
        if (take_window) begin
          best_valid  <= 1'b1;
          best_count  <= cnt;
          best_levels <= fin_levels;
        end
      end
    end
  end

endmodule

// File: rtl/battery_text_triplet_scanner.sv
// Top level of the battery text triplet scanner: input register, keyword and level
// units, result register. Depends on btts_pkg, btts_ifs, btts_hint_match, btts_level_track.
//
// Usage:
//   char_chan carries the message one byte per transaction (text_byte), with
//   last_byte set on the final byte. result_chan carries one transaction per
//   message, produced by its last byte: found plus three level/present pairs.
//   Both channels transfer when valid and ready are high at a rising clock edge.
// Result path: a last byte held in the input register is processed when it advances,
//   and its result is registered in the result register and shows on result_chan
//   from then on.
// Throughput: one byte per cycle. The input register hands its byte to the
//   keyword and level units each cycle; only a last byte waits, for the result
//   register to be free or taken in the same cycle.
// Reset: rst (synchronous, active high) empties both registers and clears the
//   history, hint flag, number and window state. All but the two registers are
//   cleared after each message's last byte too, so messages follow back to back.
// Stall: while a held result is not taken, bytes that are not last keep flowing;
//   a following last byte holds in the input register and char_chan.ready drops.

module battery_text_triplet_scanner
  import btts_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  btts_char_if.sink     char_chan,
  btts_result_if.source result_chan
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;
  logic       out_valid;
  result_t    out_data;
  step_t      step;
  logic       hint_now;
  result_t    result;

  assign s1_adv          = s1_valid && (!s1_last || !out_valid || result_chan.ready);
  assign char_chan.ready = !s1_valid || s1_adv;

  assign step.fire     = s1_adv;
  assign step.last     = s1_last;
  assign step.char_low = to_lower(s1_byte);

  btts_hint_match u_hint (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .hint_now (hint_now)
  );

  btts_level_track u_level (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .hint_now (hint_now),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_chan.valid && char_chan.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (char_chan.valid && char_chan.ready) begin
      s1_byte <= char_chan.text_byte;
      s1_last <= char_chan.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      out_data <= result;
    end
  end

  assign result_chan.valid          = out_valid;
  assign result_chan.found          = out_data.found;
  assign result_chan.left_present   = out_data.left_present;
  assign result_chan.left_level     = out_data.left_level;
  assign result_chan.right_present  = out_data.right_present;
  assign result_chan.right_level    = out_data.right_level;
  assign result_chan.holder_present = out_data.holder_present;
  assign result_chan.holder_level   = out_data.holder_level;

endmodule

// File: rtl/btts_checker.sv
// Port-level checker of the battery text triplet scanner and its bind to the top level.
// Depends on btts_pkg for the level width.

module btts_checker
  import btts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found,
  input logic               left_present,
  input logic [LEVEL_W-1:0] left_level,
  input logic               right_present,
  input logic [LEVEL_W-1:0] right_level,
  input logic               holder_present,
  input logic [LEVEL_W-1:0] holder_level
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(left_level)
      && $stable(right_level) && $stable(holder_level))
    else $error("stalled result changed or vanished");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> !left_present && !right_present && !holder_present
      && left_level == '0 && right_level == '0 && holder_level == '0)
    else $error("fields set on a result that was not found");

  a_found_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> $countones({left_present, right_present, holder_present}) >= 2)
    else $error("found with fewer than two present levels");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_present || left_level == '0) && (right_present || right_level == '0)
      && (holder_present || holder_level == '0))
    else $error("absent level is not zero");

endmodule

bind battery_text_triplet_scanner btts_checker u_btts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_chan.valid),
  .out_ready      (result_chan.ready),
  .found          (result_chan.found),
  .left_present   (result_chan.left_present),
  .left_level     (result_chan.left_level),
  .right_present  (result_chan.right_present),
  .right_level    (result_chan.right_level),
  .holder_present (result_chan.holder_present),
  .holder_level   (result_chan.holder_level)
);
